FILE: hdl/cmac_pkg.sv
// Shared types, constants and AES helper functions for the CMAC engine.
`default_nettype none
package cmac_pkg;

    localparam logic [4:0] FULL_BLOCK = 5'd16;
    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [7:0] GF_POLY    = 8'h87;
    localparam logic [3:0] LAST_ROUND = 4'd10;

    typedef struct packed {
        logic [127:0] data;
        logic [4:0]   valid_bytes;
        logic         last;
    } cmac_word_t;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        begin
            case (a)
                8'h00: r = 8'h63; 8'h01: r = 8'h7C; 8'h02: r = 8'h77; 8'h03: r = 8'h7B;
                8'h04: r = 8'hF2; 8'h05: r = 8'h6B; 8'h06: r = 8'h6F; 8'h07: r = 8'hC5;
                8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0A: r = 8'h67; 8'h0B: r = 8'h2B;
                8'h0C: r = 8'hFE; 8'h0D: r = 8'hD7; 8'h0E: r = 8'hAB; 8'h0F: r = 8'h76;
                8'h10: r = 8'hCA; 8'h11: r = 8'h82; 8'h12: r = 8'hC9; 8'h13: r = 8'h7D;
                8'h14: r = 8'hFA; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hF0;
                8'h18: r = 8'hAD; 8'h19: r = 8'hD4; 8'h1A: r = 8'hA2; 8'h1B: r = 8'hAF;
                8'h1C: r = 8'h9C; 8'h1D: r = 8'hA4; 8'h1E: r = 8'h72; 8'h1F: r = 8'hC0;
                8'h20: r = 8'hB7; 8'h21: r = 8'hFD; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
                8'h24: r = 8'h36; 8'h25: r = 8'h3F; 8'h26: r = 8'hF7; 8'h27: r = 8'hCC;
                8'h28: r = 8'h34; 8'h29: r = 8'hA5; 8'h2A: r = 8'hE5; 8'h2B: r = 8'hF1;
                8'h2C: r = 8'h71; 8'h2D: r = 8'hD8; 8'h2E: r = 8'h31; 8'h2F: r = 8'h15;
                8'h30: r = 8'h04; 8'h31: r = 8'hC7; 8'h32: r = 8'h23; 8'h33: r = 8'hC3;
                8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9A;
                8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3A: r = 8'h80; 8'h3B: r = 8'hE2;
                8'h3C: r = 8'hEB; 8'h3D: r = 8'h27; 8'h3E: r = 8'hB2; 8'h3F: r = 8'h75;
                8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2C; 8'h43: r = 8'h1A;
                8'h44: r = 8'h1B; 8'h45: r = 8'h6E; 8'h46: r = 8'h5A; 8'h47: r = 8'hA0;
                8'h48: r = 8'h52; 8'h49: r = 8'h3B; 8'h4A: r = 8'hD6; 8'h4B: r = 8'hB3;
                8'h4C: r = 8'h29; 8'h4D: r = 8'hE3; 8'h4E: r = 8'h2F; 8'h4F: r = 8'h84;
                8'h50: r = 8'h53; 8'h51: r = 8'hD1; 8'h52: r = 8'h00; 8'h53: r = 8'hED;
                8'h54: r = 8'h20; 8'h55: r = 8'hFC; 8'h56: r = 8'hB1; 8'h57: r = 8'h5B;
                8'h58: r = 8'h6A; 8'h59: r = 8'hCB; 8'h5A: r = 8'hBE; 8'h5B: r = 8'h39;
                8'h5C: r = 8'h4A; 8'h5D: r = 8'h4C; 8'h5E: r = 8'h58; 8'h5F: r = 8'hCF;
                8'h60: r = 8'hD0; 8'h61: r = 8'hEF; 8'h62: r = 8'hAA; 8'h63: r = 8'hFB;
                8'h64: r = 8'h43; 8'h65: r = 8'h4D; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
                8'h68: r = 8'h45; 8'h69: r = 8'hF9; 8'h6A: r = 8'h02; 8'h6B: r = 8'h7F;
                8'h6C: r = 8'h50; 8'h6D: r = 8'h3C; 8'h6E: r = 8'h9F; 8'h6F: r = 8'hA8;
                8'h70: r = 8'h51; 8'h71: r = 8'hA3; 8'h72: r = 8'h40; 8'h73: r = 8'h8F;
                8'h74: r = 8'h92; 8'h75: r = 8'h9D; 8'h76: r = 8'h38; 8'h77: r = 8'hF5;
                8'h78: r = 8'hBC; 8'h79: r = 8'hB6; 8'h7A: r = 8'hDA; 8'h7B: r = 8'h21;
                8'h7C: r = 8'h10; 8'h7D: r = 8'hFF; 8'h7E: r = 8'hF3; 8'h7F: r = 8'hD2;
                8'h80: r = 8'hCD; 8'h81: r = 8'h0C; 8'h82: r = 8'h13; 8'h83: r = 8'hEC;
                8'h84: r = 8'h5F; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
                8'h88: r = 8'hC4; 8'h89: r = 8'hA7; 8'h8A: r = 8'h7E; 8'h8B: r = 8'h3D;
                8'h8C: r = 8'h64; 8'h8D: r = 8'h5D; 8'h8E: r = 8'h19; 8'h8F: r = 8'h73;
                8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4F; 8'h93: r = 8'hDC;
                8'h94: r = 8'h22; 8'h95: r = 8'h2A; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
                8'h98: r = 8'h46; 8'h99: r = 8'hEE; 8'h9A: r = 8'hB8; 8'h9B: r = 8'h14;
                8'h9C: r = 8'hDE; 8'h9D: r = 8'h5E; 8'h9E: r = 8'h0B; 8'h9F: r = 8'hDB;
                8'hA0: r = 8'hE0; 8'hA1: r = 8'h32; 8'hA2: r = 8'h3A; 8'hA3: r = 8'h0A;
                8'hA4: r = 8'h49; 8'hA5: r = 8'h06; 8'hA6: r = 8'h24; 8'hA7: r = 8'h5C;
                8'hA8: r = 8'hC2; 8'hA9: r = 8'hD3; 8'hAA: r = 8'hAC; 8'hAB: r = 8'h62;
                8'hAC: r = 8'h91; 8'hAD: r = 8'h95; 8'hAE: r = 8'hE4; 8'hAF: r = 8'h79;
                8'hB0: r = 8'hE7; 8'hB1: r = 8'hC8; 8'hB2: r = 8'h37; 8'hB3: r = 8'h6D;
                8'hB4: r = 8'h8D; 8'hB5: r = 8'hD5; 8'hB6: r = 8'h4E; 8'hB7: r = 8'hA9;
                8'hB8: r = 8'h6C; 8'hB9: r = 8'h56; 8'hBA: r = 8'hF4; 8'hBB: r = 8'hEA;
                8'hBC: r = 8'h65; 8'hBD: r = 8'h7A; 8'hBE: r = 8'hAE; 8'hBF: r = 8'h08;
                8'hC0: r = 8'hBA; 8'hC1: r = 8'h78; 8'hC2: r = 8'h25; 8'hC3: r = 8'h2E;
                8'hC4: r = 8'h1C; 8'hC5: r = 8'hA6; 8'hC6: r = 8'hB4; 8'hC7: r = 8'hC6;
                8'hC8: r = 8'hE8; 8'hC9: r = 8'hDD; 8'hCA: r = 8'h74; 8'hCB: r = 8'h1F;
                8'hCC: r = 8'h4B; 8'hCD: r = 8'hBD; 8'hCE: r = 8'h8B; 8'hCF: r = 8'h8A;
                8'hD0: r = 8'h70; 8'hD1: r = 8'h3E; 8'hD2: r = 8'hB5; 8'hD3: r = 8'h66;
                8'hD4: r = 8'h48; 8'hD5: r = 8'h03; 8'hD6: r = 8'hF6; 8'hD7: r = 8'h0E;
                8'hD8: r = 8'h61; 8'hD9: r = 8'h35; 8'hDA: r = 8'h57; 8'hDB: r = 8'hB9;
                8'hDC: r = 8'h86; 8'hDD: r = 8'hC1; 8'hDE: r = 8'h1D; 8'hDF: r = 8'h9E;
                8'hE0: r = 8'hE1; 8'hE1: r = 8'hF8; 8'hE2: r = 8'h98; 8'hE3: r = 8'h11;
                8'hE4: r = 8'h69; 8'hE5: r = 8'hD9; 8'hE6: r = 8'h8E; 8'hE7: r = 8'h94;
                8'hE8: r = 8'h9B; 8'hE9: r = 8'h1E; 8'hEA: r = 8'h87; 8'hEB: r = 8'hE9;
                8'hEC: r = 8'hCE; 8'hED: r = 8'h55; 8'hEE: r = 8'h28; 8'hEF: r = 8'hDF;
                8'hF0: r = 8'h8C; 8'hF1: r = 8'hA1; 8'hF2: r = 8'h89; 8'hF3: r = 8'h0D;
                8'hF4: r = 8'hBF; 8'hF5: r = 8'hE6; 8'hF6: r = 8'h42; 8'hF7: r = 8'h68;
                8'hF8: r = 8'h41; 8'hF9: r = 8'h99; 8'hFA: r = 8'h2D; 8'hFB: r = 8'h0F;
                8'hFC: r = 8'hB0; 8'hFD: r = 8'h54; 8'hFE: r = 8'hBB; 8'hFF: r = 8'h16;
                default: r = 8'h00;
            endcase
            return r;
        end
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
    endfunction

    // Byte i of a 128-bit word, byte 0 most significant.
    function automatic logic [7:0] get_byte(input logic [127:0] w, input int i);
        return w[127 - 8 * i -: 8];
    endfunction

    function automatic logic [127:0] gf_double(input logic [127:0] a);
        return {a[126:0], 1'b0} ^ (a[127] ? {120'd0, GF_POLY} : 128'd0);
    endfunction

endpackage
`default_nettype wire

FILE: hdl/cmac_front.sv
// Front end: accepts message words and queues them for the back end.
`default_nettype none
module cmac_front
    import cmac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] data_high,
    input  wire logic [63:0] data_low,
    input  wire logic [4:0]  valid_bytes,
    input  wire logic        last,
    output logic             q_valid,
    output cmac_word_t       q_word,
    input  wire logic        q_take
);

    cmac_word_t  mem_reg [2];
    logic [1:0]  count_reg;
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic        do_push;
    logic        do_pop;
    logic [4:0]  clamped;

    assign full    = (count_reg == 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_word  = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = q_take && q_valid;
    assign clamped = (valid_bytes > FULL_BLOCK) ? FULL_BLOCK : valid_bytes;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= '{data: {data_high, data_low},
                                     valid_bytes: clamped, last: last};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cmac_aes_round.sv
// Iterative AES-128 core, one round and one round-key step per cycle.
`default_nettype none
module cmac_aes_round
    import cmac_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [127:0] block_in,
    input  wire logic [127:0] key,
    output logic              busy,
    output logic              done,
    output logic [127:0]      block_out
);

    logic [127:0] state_reg;
    logic [127:0] rkey_reg;
    logic [7:0]   rcon_reg;
    logic [3:0]   round_reg;
    logic         busy_reg;
    logic [127:0] sub_shift;
    logic [127:0] mixed;
    logic [127:0] rkey_next;
    logic [127:0] state_next;
    logic [31:0]  rot;

    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sub_shift[127 - 8 * (r + 4 * c) -: 8] =
                    sbox(get_byte(state_reg, r + 4 * ((c + r) % 4)));
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            logic [7:0] a0, a1, a2, a3, x;
            a0 = get_byte(sub_shift, 4 * c);
            a1 = get_byte(sub_shift, 4 * c + 1);
            a2 = get_byte(sub_shift, 4 * c + 2);
            a3 = get_byte(sub_shift, 4 * c + 3);
            x  = a0 ^ a1 ^ a2 ^ a3;
            mixed[127 - 32 * c -: 32] = {a0 ^ x ^ xtime(a0 ^ a1), a1 ^ x ^ xtime(a1 ^ a2),
                                         a2 ^ x ^ xtime(a2 ^ a3), a3 ^ x ^ xtime(a3 ^ a0)};
        end
        rot = {sbox(get_byte(rkey_reg, 13)) ^ rcon_reg, sbox(get_byte(rkey_reg, 14)),
               sbox(get_byte(rkey_reg, 15)), sbox(get_byte(rkey_reg, 12))};
        rkey_next[127:96] = rkey_reg[127:96] ^ rot;
        rkey_next[95:64]  = rkey_reg[95:64] ^ rkey_next[127:96];
        rkey_next[63:32]  = rkey_reg[63:32] ^ rkey_next[95:64];
        rkey_next[31:0]   = rkey_reg[31:0] ^ rkey_next[63:32];
        state_next = ((round_reg == LAST_ROUND) ? sub_shift : mixed) ^ rkey_next;
    end

    assign busy      = busy_reg;
    assign block_out = state_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            state_reg <= block_in ^ key;
            rkey_reg  <= key;
            rcon_reg  <= 8'h01;
        end
        else if (busy_reg)
        begin
            state_reg <= state_next;
            rkey_reg  <= rkey_next;
            rcon_reg  <= xtime(rcon_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            round_reg <= 4'd0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                round_reg <= 4'd1;
            end
            else if (busy_reg)
            begin
                round_reg <= round_reg + 4'd1;
                if (round_reg == LAST_ROUND)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: hdl/cmac_back.sv
// Back end: subkey derivation, chaining, padding and tag output.
`default_nettype none
module cmac_back
    import cmac_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [127:0] key,
    input  wire logic         key_write,
    input  wire logic         q_valid,
    input  wire cmac_word_t   q_word,
    output logic              q_take,
    output logic              empty,
    input  wire logic         pop,
    output logic [63:0]       tag_high,
    output logic [63:0]       tag_low
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SUBKEY = 2'd1;
    localparam logic [1:0] ST_BLOCK  = 2'd2;

    logic [1:0]   state_reg;
    logic         ready_reg;
    logic         is_last_reg;
    logic [127:0] chain_reg;
    logic [127:0] k1_reg;
    logic [127:0] k2_reg;
    logic [127:0] tag_reg;
    logic         tag_valid_reg;
    logic         aes_start;
    logic [127:0] aes_in;
    logic         aes_busy;
    logic         aes_done;
    logic [127:0] aes_out;
    logic [127:0] padded;
    logic [127:0] last_in;
    logic         can_start;

    cmac_aes_round u_aes (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (aes_start),
        .block_in  (aes_in),
        .key       (key),
        .busy      (aes_busy),
        .done      (aes_done),
        .block_out (aes_out)
    );

    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            if (5'(i) < q_word.valid_bytes)
            begin
                padded[127 - 8 * i -: 8] = get_byte(q_word.data, i);
            end
            else if (5'(i) == q_word.valid_bytes)
            begin
                padded[127 - 8 * i -: 8] = PAD_BYTE;
            end
            else
            begin
                padded[127 - 8 * i -: 8] = 8'h00;
            end
        end
        if (q_word.valid_bytes == FULL_BLOCK)
        begin
            last_in = q_word.data ^ k1_reg;
        end
        else
        begin
            last_in = padded ^ k2_reg;
        end
    end

    // A block may start once the unit is free and any earlier tag has left.
    assign can_start = (state_reg == ST_IDLE) && !aes_busy && q_valid && !key_write
                       && !(tag_valid_reg && !pop);

    always_comb
    begin
        aes_start = 1'b0;
        aes_in    = 128'd0;
        q_take    = 1'b0;
        if (can_start)
        begin
            aes_start = 1'b1;
            if (!ready_reg)
            begin
                aes_in = 128'd0;
            end
            else
            begin
                q_take = 1'b1;
                aes_in = q_word.last ? (last_in ^ chain_reg) : (q_word.data ^ chain_reg);
            end
        end
    end

    assign empty    = !tag_valid_reg;
    assign tag_high = tag_reg[127:64];
    assign tag_low  = tag_reg[63:0];

    always_ff @(posedge clk)
    begin
        if (aes_done && state_reg == ST_SUBKEY)
        begin
            k1_reg <= gf_double(aes_out);
            k2_reg <= gf_double(gf_double(aes_out));
        end
        if (aes_done && state_reg == ST_BLOCK && is_last_reg)
        begin
            tag_reg <= aes_out;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ready_reg     <= 1'b0;
            is_last_reg   <= 1'b0;
            chain_reg     <= 128'd0;
            tag_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && tag_valid_reg)
            begin
                tag_valid_reg <= 1'b0;
            end
            if (key_write)
            begin
                ready_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (aes_start)
                    begin
                        is_last_reg <= q_word.last;
                        state_reg   <= ready_reg ? ST_BLOCK : ST_SUBKEY;
                    end
                end
                ST_SUBKEY:
                begin
                    if (aes_done)
                    begin
                        ready_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_BLOCK:
                begin
                    if (aes_done)
                    begin
                        state_reg <= ST_IDLE;
                        if (is_last_reg)
                        begin
                            chain_reg     <= 128'd0;
                            tag_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            chain_reg <= aes_out;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: hdl/aes128_cmac_engine.sv
// Top level of the AES-128 CMAC engine.
//
// Message words enter through push/full and carry a 128-bit block, a valid
// byte count and a last flag. A two-entry queue takes words while the back
// end works, so a new word is accepted while an earlier block is encrypted.
// The back end runs one AES round per cycle in a single shared core, which
// serves the subkey pass and every block; a block starts only from idle, and
// the first block after reset or a key write waits for the subkey pass.
// Only a last word yields a tag; it appears on tag_high/tag_low while empty
// is low and leaves on pop. Further blocks wait while a tag is not taken.
// Key registers 0 (high half) and 1 (low half) are written through the
// cfg channel, which is always ready; a write forces a new subkey pass.
// Reset clears the queue, the chain value, the key and the tag-valid flag.
`default_nettype none
module aes128_cmac_engine
    import cmac_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [63:0] data_high,
    input  wire logic [63:0] data_low,
    input  wire logic [4:0]  valid_bytes,
    input  wire logic        last,
    output logic             empty,
    input  wire logic        pop,
    output logic [63:0]      tag_high,
    output logic [63:0]      tag_low,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_index,
    input  wire logic [63:0] cfg_data
);

    localparam logic REG_KEY_HIGH = 1'b0;
    localparam logic REG_KEY_LOW  = 1'b1;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic        q_valid;
    cmac_word_t  q_word;
    logic        q_take;
    logic        key_write;

    assign cfg_ready = 1'b1;
    assign key_write = cfg_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_KEY_HIGH)
            begin
                key_high_reg <= cfg_data;
            end
            if (cfg_index == REG_KEY_LOW)
            begin
                key_low_reg <= cfg_data;
            end
        end
    end

    cmac_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .data_high   (data_high),
        .data_low    (data_low),
        .valid_bytes (valid_bytes),
        .last        (last),
        .q_valid     (q_valid),
        .q_word      (q_word),
        .q_take      (q_take)
    );

    cmac_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .key       ({key_high_reg, key_low_reg}),
        .key_write (key_write),
        .q_valid   (q_valid),
        .q_word    (q_word),
        .q_take    (q_take),
        .empty     (empty),
        .pop       (pop),
        .tag_high  (tag_high),
        .tag_low   (tag_low)
    );

endmodule
`default_nettype wire

FILE: tb/tb_aes128_cmac_engine.sv
// Self-checking testbench for the AES-128 CMAC engine, tags checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

class cmac_tag_board;
    logic [127:0] expected_tags[$];
    int           mismatch_count;
    int           tag_count;

    function void note_tag(input logic [127:0] tag);
        expected_tags.push_back(tag);
    endfunction

    function void check_tag(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] want;
        if (expected_tags.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Unexpected tag %h_%h", hi, lo);
            return;
        end
        want = expected_tags.pop_front();
        tag_count++;
        if (want[127:64] !== hi || want[63:0] !== lo)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Tag mismatch: expected %h_%h, actual %h_%h",
                         want[127:64], want[63:0], hi, lo);
        end
    endfunction
endclass

module tb_aes128_cmac_engine;
    import cmac_pkg::*;

    localparam int KEY_HIGH_REG = 0;
    localparam int KEY_LOW_REG  = 1;
    localparam longint CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [63:0] data_high;
    logic [63:0] data_low;
    logic [4:0]  valid_bytes;
    logic        last;
    logic        empty;
    logic        pop;
    logic [63:0] tag_high;
    logic [63:0] tag_low;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [63:0] cfg_data;

    aes128_cmac_engine dut (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full),
        .data_high(data_high), .data_low(data_low), .valid_bytes(valid_bytes),
        .last(last), .empty(empty), .pop(pop), .tag_high(tag_high),
        .tag_low(tag_low), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    cmac_tag_board board;

    logic [127:0] aes_key;
    logic [127:0] chain;
    logic [127:0] subkey1;
    logic [127:0] subkey2;
    logic         subkeys_valid;

    int  send_idle_pct;
    int  take_idle_pct;
    longint cycle_count;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r, x;
        int i;
        r = 8'h00;
        x = a;
        for (i = 0; i < 8; i++)
        begin
            if (b[i])
                r ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
        end
        return r;
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] a);
        logic [7:0] p, q, inv;
        int i;
        // Inverse by exponentiation a^254 in GF(2^8), then the affine map.
        p = a;
        inv = 8'h01;
        for (i = 0; i < 7; i++)
        begin
            p = gf_mul(p, p);
            inv = gf_mul(inv, p);
        end
        q = inv;
        return q ^ {q[6:0], q[7]} ^ {q[5:0], q[7:6]} ^ {q[4:0], q[7:5]}
               ^ {q[3:0], q[7:4]} ^ 8'h63;
    endfunction

    function automatic logic [127:0] aes_encrypt(input logic [127:0] blk,
                                                 input logic [127:0] key);
        logic [7:0] s[16], k[16], t[16];
        logic [7:0] rc, a0, a1, a2, a3, x;
        logic [127:0] res;
        int rnd, i, c, r;
        rc = 8'h01;
        for (i = 0; i < 16; i++)
        begin
            s[i] = blk[127 - 8 * i -: 8] ^ key[127 - 8 * i -: 8];
            k[i] = key[127 - 8 * i -: 8];
        end
        for (rnd = 1; rnd <= 10; rnd++)
        begin
            for (c = 0; c < 4; c++)
                for (r = 0; r < 4; r++)
                    t[r + 4 * c] = sub_byte(s[r + 4 * ((c + r) % 4)]);
            if (rnd != 10)
            begin
                for (c = 0; c < 4; c++)
                begin
                    a0 = t[4 * c]; a1 = t[4 * c + 1]; a2 = t[4 * c + 2]; a3 = t[4 * c + 3];
                    x = a0 ^ a1 ^ a2 ^ a3;
                    t[4 * c]     = a0 ^ x ^ gf_mul(a0 ^ a1, 8'h02);
                    t[4 * c + 1] = a1 ^ x ^ gf_mul(a1 ^ a2, 8'h02);
                    t[4 * c + 2] = a2 ^ x ^ gf_mul(a2 ^ a3, 8'h02);
                    t[4 * c + 3] = a3 ^ x ^ gf_mul(a3 ^ a0, 8'h02);
                end
            end
            a0 = k[13]; a1 = k[14]; a2 = k[15]; a3 = k[12];
            k[0] ^= sub_byte(a0) ^ rc;
            k[1] ^= sub_byte(a1);
            k[2] ^= sub_byte(a2);
            k[3] ^= sub_byte(a3);
            rc = gf_mul(rc, 8'h02);
            for (i = 4; i < 16; i++)
                k[i] ^= k[i - 4];
            for (i = 0; i < 16; i++)
                s[i] = t[i] ^ k[i];
        end
        for (i = 0; i < 16; i++)
            res[127 - 8 * i -: 8] = s[i];
        return res;
    endfunction

    function automatic logic [127:0] double_block(input logic [127:0] a);
        return {a[126:0], 1'b0} ^ (a[127] ? 128'h87 : 128'h0);
    endfunction

    // Advances the predicted engine by one block; returns 1 with a tag on a last block.
    function automatic bit predict_block(input logic [127:0] blk, input logic [4:0] nbytes,
                                         input logic is_last, output logic [127:0] tag);
        logic [127:0] m;
        int n, i;
        tag = '0;
        if (!subkeys_valid)
        begin
            subkey1 = double_block(aes_encrypt(128'h0, aes_key));
            subkey2 = double_block(subkey1);
            subkeys_valid = 1'b1;
        end
        if (!is_last)
        begin
            chain = aes_encrypt(chain ^ blk, aes_key);
            return 0;
        end
        n = (nbytes > 16) ? 16 : nbytes;
        if (n == 16)
            m = blk ^ subkey1;
        else
        begin
            m = '0;
            for (i = 0; i < n; i++)
                m[127 - 8 * i -: 8] = blk[127 - 8 * i -: 8];
            m[127 - 8 * n -: 8] = PAD_BYTE;
            m ^= subkey2;
        end
        tag = aes_encrypt(m ^ chain, aes_key);
        chain = '0;
        return 1;
    endfunction

    // Push stays high after an accepted word until the next word or an idle cycle.
    task automatic send_word(input logic [127:0] blk, input logic [4:0] nbytes,
                             input logic is_last);
        logic [127:0] tag;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push <= 1'b1;
        data_high <= blk[127:64];
        data_low <= blk[63:0];
        valid_bytes <= nbytes;
        last <= is_last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (predict_block(blk, nbytes, is_last, tag))
            board.note_tag(tag);
        @(negedge clk);
    endtask

    task automatic write_key(input int index, input logic [63:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= index[0];
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (index == KEY_HIGH_REG)
            aes_key[127:64] = value;
        else
            aes_key[63:0] = value;
        subkeys_valid = 1'b0;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic drain_tags();
        push <= 1'b0;
        while (board.expected_tags.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    function automatic logic [127:0] random_block();
        return {$urandom(), $urandom(), $urandom(), $urandom()};
    endfunction

    task automatic send_message(input int nblocks);
        int i;
        logic [4:0] nb;
        for (i = 0; i < nblocks - 1; i++)
            send_word(random_block(), 5'($urandom_range(31)), 1'b0);
        nb = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
        send_word(random_block(), nb, 1'b1);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && pop && !empty)
            board.check_tag(tag_high, tag_low);
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (take_idle_pct > 0 && $urandom_range(99) < take_idle_pct)
            pop <= 1'b0;
        else
            pop <= 1'b1;
    end

    initial
    begin
        int sent, phase, i;
        board = new();
        cycle_count = 0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        data_high = '0;
        data_low = '0;
        valid_bytes = '0;
        last = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 1'b0;
        cfg_data = '0;
        aes_key = '0;
        chain = '0;
        subkey1 = '0;
        subkey2 = '0;
        subkeys_valid = 1'b0;
        send_idle_pct = 0;
        take_idle_pct = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part under the reset key, then the RFC 4493 key, then an all-ones key.
        send_word(128'h0, 5'd0, 1'b1);
        send_word({64{2'b10}}, 5'd16, 1'b1);
        send_word({128{1'b1}}, 5'd31, 1'b1);
        send_word({128{1'b1}}, 5'd17, 1'b1);
        drain_tags();
        write_key(KEY_HIGH_REG, 64'h2b7e151628aed2a6);
        write_key(KEY_LOW_REG, 64'habf7158809cf4f3c);
        send_word(128'h0, 5'd0, 1'b1);
        send_word(128'h6bc1bee22e409f96e93d7e117393172a, 5'd16, 1'b1);
        send_word(128'h6bc1bee22e409f96e93d7e117393172a, 5'd3, 1'b0);
        send_word(128'hae2d8a571e03ac9c9eb76fac45af8e51, 5'd7, 1'b0);
        send_word(128'h30c81c46a35ce411e5fbc1191a0a52ef, 5'd15, 1'b1);
        for (i = 1; i < 16; i += 2)
            send_word(random_block(), 5'(i), 1'b1);
        drain_tags();
        write_key(KEY_HIGH_REG, {64{1'b1}});
        write_key(KEY_LOW_REG, {64{1'b1}});
        send_word({128{1'b1}}, 5'd1, 1'b0);
        send_word({128{1'b1}}, 5'd16, 1'b1);
        drain_tags();

        sent = 0;
        for (phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 75 : 0;
            take_idle_pct = (phase == 0) ? 75 : (phase == 1) ? 6 : 0;
            while (sent < 250 * (phase + 1))
            begin
                i = ($urandom_range(7) == 0) ? $urandom_range(8) + 1 : $urandom_range(3) + 1;
                send_message(i);
                sent += i;
            end
            drain_tags();
            write_key(KEY_HIGH_REG, (phase == 1) ? 64'h0 : {$urandom(), $urandom()});
            write_key(KEY_LOW_REG, {$urandom(), $urandom()});
        end
        send_message(2);
        drain_tags();

        if (board.mismatch_count == 0 && board.expected_tags.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

`default_nettype wire
